### rtl/stpwm_pkg.sv
// ----------------------------------------------------------------------------
// stpwm_pkg
// Shared constants, types and curve tables for the stick-to-PWM mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package stpwm_pkg;

  localparam int RegW          = 12;
  localparam int NumRegs       = 8;
  localparam int CfgIdxW       = 3;
  localparam int FracW         = 16;
  localparam int DivSteps      = FracW;
  localparam int PowDepth      = 6;
  localparam int CapScaleDef   = 256;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegGuideCentre = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGuideMin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGuideMax    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeadZone    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPwmCentre   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPwmMin      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPwmMax      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegExpo        = 3'd7;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    12'd2048, 12'd0, 12'd4095, 12'd0, 12'd2048, 12'd0, 12'd4095, 12'd0
  };

  typedef enum logic [1:0] {
    KIND_DEAD,
    KIND_FULL,
    KIND_CURVE
  } kind_e;

  typedef struct packed {
    logic  valid;
    logic  side;   // 1: high side, 0: low side
    kind_e kind;
  } tag_t;

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // 2^(i/16) in Q16
  function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
    logic [17:0] v;
    unique case (idx)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88753;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = 18'd65536;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/stpwm_div.sv
// ----------------------------------------------------------------------------
// stpwm_div
// Pipelined restoring divider: one quotient bit per stage, num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module stpwm_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire stpwm_pkg::tag_t                   tag_i,
  input  wire logic [stpwm_pkg::RegW-1:0]        num_i,
  input  wire logic [stpwm_pkg::RegW-1:0]        den_i,
  output stpwm_pkg::tag_t                        tag_o,
  output logic      [stpwm_pkg::FracW-1:0]       quo_o
);

  localparam int W = stpwm_pkg::RegW;
  localparam int S = stpwm_pkg::DivSteps;

  stpwm_pkg::tag_t           tag_q [S];
  logic [W-1:0]              rem_q [S];
  logic [W-1:0]              den_q [S];
  logic [stpwm_pkg::FracW-1:0] quo_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    stpwm_pkg::tag_t             tag_prev;
    logic [W-1:0]                rem_prev;
    logic [W-1:0]                den_prev;
    logic [stpwm_pkg::FracW-1:0] quo_prev;
    logic [W:0]                  dbl;
    logic [W:0]                  dif;
    logic                        ge;

    if (k == 0) begin : g_first
      assign tag_prev = tag_i;
      assign rem_prev = num_i;
      assign den_prev = den_i;
      assign quo_prev = '0;
    end else begin : g_next
      assign tag_prev = tag_q[k-1];
      assign rem_prev = rem_q[k-1];
      assign den_prev = den_q[k-1];
      assign quo_prev = quo_q[k-1];
    end

    // shift in a zero, subtract when it fits
    assign dbl = {rem_prev, 1'b0};
    assign dif = dbl - {1'b0, den_prev};
    assign ge  = (dbl >= {1'b0, den_prev});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= tag_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? dif[W-1:0] : dbl[W-1:0];
      den_q[k] <= den_prev;
      quo_q[k] <= {quo_prev[stpwm_pkg::FracW-2:0], ge};
    end
  end

  assign tag_o = tag_q[S-1];
  assign quo_o = quo_q[S-1];

endmodule

`default_nettype wire

### rtl/stpwm_pow.sv
// ----------------------------------------------------------------------------
// stpwm_pow
// Six-stage power unit: f^(expo/256) through table log2 and exp2.
// ----------------------------------------------------------------------------
`default_nettype none

module stpwm_pow (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [stpwm_pkg::RegW-1:0]        expo_i,
  input  wire stpwm_pkg::tag_t                   tag_i,
  input  wire logic [stpwm_pkg::FracW-1:0]       frac_i,
  output stpwm_pkg::tag_t                        tag_o,
  output logic      [stpwm_pkg::FracW-1:0]       frac_o,
  output logic      [stpwm_pkg::FracW:0]         pow_o
);

  localparam int D  = stpwm_pkg::PowDepth;
  localparam int FW = stpwm_pkg::FracW;

  stpwm_pkg::tag_t tag_q  [D];
  logic [FW-1:0]   frac_q [D];

  // stage 1: normalize
  logic [3:0]    lead;
  logic [FW-1:0] norm;
  logic [3:0]    m1_q;
  logic [FW-1:0] t1_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < FW; i++) begin
      if (frac_i[i]) lead = 4'(i);
    end
    norm = frac_i << (4'd15 - lead);
  end

  // stage 2: log2 mantissa lookup and interpolation
  logic [4:0]  li;
  logic [16:0] lbase;
  logic [12:0] ldiff;
  logic [24:0] lprod;
  logic [16:0] lg2_q;
  logic [3:0]  m2_q;

  assign li    = {1'b0, t1_q[15:12]};
  assign lbase = stpwm_pkg::log2_tab(li);
  assign ldiff = 13'(stpwm_pkg::log2_tab(li + 5'd1) - lbase);
  assign lprod = 25'(ldiff) * 25'(t1_q[11:0]);

  // stage 3: L = -log2(f)
  logic [20:0] l3_q;

  // stage 4: E = L * expo / 256
  logic [32:0] eprod;
  logic [24:0] e4_q;

  assign eprod = 33'(l3_q) * 33'(expo_i);

  // stage 5: exp2 of the fraction
  logic [15:0] efr;
  logic [15:0] et;
  logic [4:0]  ei;
  logic [17:0] ebase;
  logic [12:0] ediff;
  logic [24:0] eprd;
  logic [17:0] mant_d;
  logic [9:0]  sh_d;
  logic [17:0] mant5_q;
  logic [9:0]  sh5_q;

  assign efr   = e4_q[15:0];
  assign et    = 16'(17'h10000 - 17'(efr));
  assign ei    = {1'b0, et[15:12]};
  assign ebase = stpwm_pkg::exp2_tab(ei);
  assign ediff = 13'(stpwm_pkg::exp2_tab(ei + 5'd1) - ebase);
  assign eprd  = 25'(ediff) * 25'(et[11:0]);

  always_comb begin
    if (efr == '0) begin
      mant_d = 18'h10000;
      sh_d   = {1'b0, e4_q[24:16]};
    end else begin
      mant_d = ebase + 18'(eprd[24:12]);
      sh_d   = {1'b0, e4_q[24:16]} + 10'd1;
    end
  end

  // stage 6: scale by the integer part
  logic [17:0] pow6_q;

  for (genvar k = 0; k < D; k++) begin : g_tag
    stpwm_pkg::tag_t tag_prev;
    logic [FW-1:0]   frac_prev;
    if (k == 0) begin : g_first
      assign tag_prev  = tag_i;
      assign frac_prev = frac_i;
    end else begin : g_next
      assign tag_prev  = tag_q[k-1];
      assign frac_prev = frac_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= tag_prev;
      end
    end
    always_ff @(posedge clk_i) begin
      frac_q[k] <= frac_prev;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= lead;
    t1_q    <= {norm[14:0], 1'b0};
    lg2_q   <= lbase + 17'(lprod[24:12]);
    m2_q    <= m1_q;
    l3_q    <= {5'd16 - {1'b0, m2_q}, 16'd0} - 21'(lg2_q);
    e4_q    <= eprod[32:8];
    mant5_q <= mant_d;
    sh5_q   <= sh_d;
    pow6_q  <= (sh5_q >= 10'd24) ? 18'd0 : (mant5_q >> sh5_q[4:0]);
  end

  assign tag_o  = tag_q[D-1];
  assign frac_o = frac_q[D-1];
  assign pow_o  = pow6_q[FW:0];

endmodule

`default_nettype wire

### rtl/stick_to_pwm_deadzone_expo_core.sv
// ----------------------------------------------------------------------------
// stick_to_pwm_deadzone_expo_core
// Joystick reading to PWM drive value with dead band and expo curve.
// ----------------------------------------------------------------------------
// A reading is taken on every clock edge where start is high (busy is always
// low), and its drive value appears on pwm_value_o with valid_o high for
// exactly one cycle once it has passed through every stage; one reading per
// cycle is sustained. The pipeline is the 16-stage divider (one quotient bit
// per stage) and the 6-stage log2/exp2 power unit, plus setup, product and
// output stages. The receiver cannot stall, so there is no back-pressure. Write
// configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_to_pwm_deadzone_expo_core #(
  parameter int CAP_SCALE = stpwm_pkg::CapScaleDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [stpwm_pkg::RegW-1:0]        guide_reading_i,
  output logic                                   valid_o,
  output logic      [stpwm_pkg::RegW-1:0]        pwm_value_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [stpwm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [stpwm_pkg::RegW-1:0]        cfg_data_i
);

  localparam int W       = stpwm_pkg::RegW;
  localparam int FW      = stpwm_pkg::FracW;
  localparam int CapW    = $clog2(CAP_SCALE + 1) + 1;
  localparam int CqW     = W + 1 + CapW;
  localparam int PW      = CqW + FW + 2;
  localparam int ValW    = ((PW > 37) ? PW : 37) + 1;
  localparam int Latency = 1 + stpwm_pkg::DivSteps + stpwm_pkg::PowDepth + 2;

  localparam logic signed [CapW-1:0] CapS = CapW'(CAP_SCALE);

  // Configuration registers
  logic [W-1:0] cfg_q [stpwm_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= stpwm_pkg::RegReset;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic [W-1:0] gc, gmin, gmax, dz, pc, pmin, pmax, expo;
  assign gc   = cfg_q[stpwm_pkg::RegGuideCentre];
  assign gmin = cfg_q[stpwm_pkg::RegGuideMin];
  assign gmax = cfg_q[stpwm_pkg::RegGuideMax];
  assign dz   = cfg_q[stpwm_pkg::RegDeadZone];
  assign pc   = cfg_q[stpwm_pkg::RegPwmCentre];
  assign pmin = cfg_q[stpwm_pkg::RegPwmMin];
  assign pmax = cfg_q[stpwm_pkg::RegPwmMax];
  assign expo = cfg_q[stpwm_pkg::RegExpo];

  // Capped half ranges, held from the registers (Q.8, signed)
  logic signed [W:0]     range_lo, range_hi;
  logic signed [CqW-1:0] cap_lo_q, cap_hi_q;

  assign range_lo = $signed({1'b0, pc}) - $signed({1'b0, pmin});
  assign range_hi = $signed({1'b0, pmax}) - $signed({1'b0, pc});

  always_ff @(posedge clk_i) begin
    cap_lo_q <= CqW'(range_lo) * CqW'(CapS);
    cap_hi_q <= CqW'(range_hi) * CqW'(CapS);
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: classify the reading and form numerator / denominator
  logic signed [W+1:0] r_s, gc_s, gmin_s, gmax_s, dz_s;
  logic signed [W+1:0] num_lo, den_lo, num_hi, den_hi;
  logic                is_lo, is_hi, full_lo, full_hi;
  stpwm_pkg::tag_t     s1_tag_d, s1_tag_q;
  logic [W-1:0]        s1_num_d, s1_num_q, s1_den_d, s1_den_q;

  assign r_s    = $signed({2'b0, guide_reading_i});
  assign gc_s   = $signed({2'b0, gc});
  assign gmin_s = $signed({2'b0, gmin});
  assign gmax_s = $signed({2'b0, gmax});
  assign dz_s   = $signed({2'b0, dz});

  assign is_lo  = (gc_s - r_s) > dz_s;
  assign is_hi  = (r_s - gc_s) > dz_s;
  assign num_lo = gc_s - dz_s - r_s;
  assign den_lo = gc_s - gmin_s - dz_s;
  assign num_hi = r_s - gc_s - dz_s;
  assign den_hi = gmax_s - gc_s - dz_s;

  // At or past a limit, an empty travel, or a full fraction: take full range
  assign full_lo = (r_s <= gmin_s) || (den_lo <= 0) || (num_lo >= den_lo);
  assign full_hi = (r_s >= gmax_s) || (den_hi <= 0) || (num_hi >= den_hi);

  always_comb begin
    s1_tag_d.valid = accept;
    s1_tag_d.side  = is_hi;
    s1_num_d       = is_hi ? num_hi[W-1:0] : num_lo[W-1:0];
    s1_den_d       = is_hi ? den_hi[W-1:0] : den_lo[W-1:0];
    priority if (is_lo) begin
      s1_tag_d.kind = full_lo ? stpwm_pkg::KIND_FULL : stpwm_pkg::KIND_CURVE;
    end else if (is_hi) begin
      s1_tag_d.kind = full_hi ? stpwm_pkg::KIND_FULL : stpwm_pkg::KIND_CURVE;
    end else begin
      s1_tag_d.kind = stpwm_pkg::KIND_DEAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
    end else begin
      s1_tag_q <= s1_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q <= s1_num_d;
    s1_den_q <= s1_den_d;
  end

  // Divider: fraction of travel in Q0.16
  stpwm_pkg::tag_t div_tag;
  logic [FW-1:0]   div_quo;

  stpwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s1_tag_q),
    .num_i  (s1_num_q),
    .den_i  (s1_den_q),
    .tag_o  (div_tag),
    .quo_o  (div_quo)
  );

  // Power unit
  stpwm_pkg::tag_t pow_tag;
  logic [FW-1:0]   pow_frac;
  logic [FW:0]     pow_val;

  stpwm_pow u_pow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .expo_i (expo),
    .tag_i  (div_tag),
    .frac_i (div_quo),
    .tag_o  (pow_tag),
    .frac_o (pow_frac),
    .pow_o  (pow_val)
  );

  // Product stage: pick the Q16 factor and scale the capped range
  logic [FW:0]           p_sel;
  logic signed [CqW-1:0] cap_sel;
  stpwm_pkg::tag_t       pr_tag_q;
  logic signed [PW-1:0]  prod_d, prod_q;
  logic [FW:0]           p_q;

  always_comb begin
    unique case (pow_tag.kind)
      stpwm_pkg::KIND_FULL:  p_sel = 17'h10000;
      stpwm_pkg::KIND_CURVE: p_sel = (expo == '0) ? {1'b0, pow_frac} : pow_val;
      default:               p_sel = '0;
    endcase
  end

  assign cap_sel = pow_tag.side ? cap_hi_q : cap_lo_q;
  assign prod_d  = PW'(cap_sel) * PW'($signed({1'b0, p_sel}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_tag_q <= '0;
    end else begin
      pr_tag_q <= pow_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    p_q    <= p_sel;
  end

  // Output stage: add to or subtract from centre, truncate, saturate
  logic signed [ValW-1:0] base, val;
  logic [W-1:0]           pwm_d, pwm_q;
  logic                   valid_q;

  assign base = ValW'($signed({1'b0, pc, 24'd0}));
  assign val  = pr_tag_q.side ? (base + ValW'(prod_q)) : (base - ValW'(prod_q));

  always_comb begin
    priority if (val[ValW-1]) begin
      pwm_d = '0;
    end else if (|val[ValW-2:36]) begin
      pwm_d = '1;
    end else begin
      pwm_d = val[35:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pr_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pwm_q <= pwm_d;
  end

  assign valid_o     = valid_q;
  assign pwm_value_o = pwm_q;

  // Every accepted transaction comes out exactly once, a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(accept && rst_ni, Latency))
    else $error("result strobe does not match accepted transaction");

  // A reading inside the dead band drives the centre value
  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pr_tag_q.valid && pr_tag_q.kind == stpwm_pkg::KIND_DEAD) |=>
    (pwm_value_o == $past(pc)))
    else $error("dead band result differs from pwm centre");

  // The Q16 factor never exceeds one
  a_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pr_tag_q.valid |-> (p_q <= 17'h10000))
    else $error("curve factor above full scale");

endmodule

`default_nettype wire
